@@ rtl/tat_pkg.sv @@
`default_nettype none

package tat_pkg;

    localparam int TAT_DEPTH_DEFAULT = 16;
    localparam int ID_W    = 16;
    localparam int TIME_W  = 48;
    localparam int SPAN_W  = 24;
    localparam int REP_W   = 16;

    typedef enum logic [1:0] {
        REQ_SCHEDULE = 2'd0,
        REQ_PERIODIC = 2'd1,
        REQ_CANCEL   = 2'd2,
        REQ_TICK     = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_SCHEDULED = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_INVALID   = 3'd2,
        ST_FULL      = 3'd3,
        ST_CANCELLED = 3'd4,
        ST_NOT_FOUND = 3'd5,
        ST_FIRED     = 3'd6,
        ST_NONE_DUE  = 3'd7
    } status_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] due;
        logic              periodic;
        logic [REP_W-1:0]  repeats;
        logic [SPAN_W-1:0] period;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

@@ rtl/tat_in_if.sv @@
`default_nettype none

interface tat_in_if;
    import tat_pkg::*;

    logic                valid;
    logic                ready;
    req_t                req_type;
    logic [ID_W-1:0]     action_id;
    logic [SPAN_W-1:0]   delay;
    logic [SPAN_W-1:0]   period;
    logic [REP_W-1:0]    repeat_total;

    modport source (output valid, req_type, action_id, delay, period, repeat_total,
                    input ready);
    modport sink   (input valid, req_type, action_id, delay, period, repeat_total,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/tat_out_if.sv @@
`default_nettype none

interface tat_out_if #(
    parameter int CW = 5
);
    import tat_pkg::*;

    logic            valid;
    logic            ready;
    status_t         status;
    logic [ID_W-1:0] fired_id;
    logic [CW-1:0]   entries_in_use;
    logic            last;

    modport source (output valid, status, fired_id, entries_in_use, last, input ready);
    modport sink   (input valid, status, fired_id, entries_in_use, last, output ready);
endinterface

`default_nettype wire

@@ rtl/tat_ram.sv @@
`default_nettype none

module tat_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [$clog2(D)-1:0] waddr,
    input  wire logic [W-1:0]         wdata,
    input  wire logic [$clog2(D)-1:0] raddr,
    output logic      [W-1:0]         rdata
);
    logic [W-1:0] mem [D];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

`default_nettype wire

@@ rtl/timed_action_table.sv @@
// Timed action table.
// in_ch carries requests: schedule after delay, schedule periodic, cancel, tick.
// out_ch carries results; each request gives one result, except a tick, which
// gives one "fired" beat per fired entry in table order (or one "none due" beat).
// The beat marked last closes the request; entries_in_use is the table
// occupancy after the whole request.
// One request at a time: in_ch.ready is high only while the sequencer is idle.
// Periodic requests and schedules with id zero skip the table walk. Schedule,
// cancel and tick walk the table through one read port, one entry a cycle; a
// tick then reads each fired id back from a small buffer memory before its
// fired beat.
// A stalled out_ch holds its beat and stops the sequencer at its next result.
// Reset clears time and occupancy; the table memories need no clearing since
// only slots below the occupancy are ever read.
`default_nettype none

module timed_action_table #(
    parameter int TABLE_DEPTH = tat_pkg::TAT_DEPTH_DEFAULT,
    parameter int CW          = $clog2(TABLE_DEPTH + 1)
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    tat_in_if.sink     in_ch,
    tat_out_if.source  out_ch
);
    import tat_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH,
        S_EMIT_RD,
        S_EMIT_WT
    } state_t;

    state_t              state_reg;
    req_t                op_reg;
    logic [ID_W-1:0]     id_reg;
    logic [SPAN_W-1:0]   delay_reg;
    logic [SPAN_W-1:0]   period_reg;
    logic [REP_W-1:0]    rep_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [CW-1:0]       used_reg;
    logic [CW-1:0]       rd_idx_reg;
    logic [CW-1:0]       wr_idx_reg;
    logic [CW-1:0]       nf_reg;
    logic [CW-1:0]       k_reg;
    logic                eval_vld_reg;
    logic                found_reg;

    logic                out_vld_reg;
    status_t             out_status_reg;
    logic [ID_W-1:0]     out_id_reg;
    logic [CW-1:0]       out_used_reg;
    logic                out_last_reg;

    logic                tbl_we;
    logic [AW-1:0]       tbl_waddr;
    entry_t              tbl_wdata;
    entry_t              tbl_rdata;
    logic                fire_we;
    logic [ID_W-1:0]     fire_rdata;

    logic                out_free;
    logic                load_beat;
    logic                hit;
    logic                rearm;
    logic                keep;
    logic                issue;
    entry_t              upd;

    assign in_ch.ready           = (state_reg == S_IDLE);
    assign out_ch.valid          = out_vld_reg;
    assign out_ch.status         = out_status_reg;
    assign out_ch.fired_id       = out_id_reg;
    assign out_ch.entries_in_use = out_used_reg;
    assign out_ch.last           = out_last_reg;

    assign out_free = !out_vld_reg || out_ch.ready;
    assign issue    = (state_reg == S_SCAN) && (rd_idx_reg != used_reg);
    // a beat is loaded by every finish except a tick that goes on to emit fired ids, and by every fired-id emit
    assign load_beat = out_free
                       && ((state_reg == S_FINISH && !(op_reg == REQ_TICK && nf_reg != '0))
                           || state_reg == S_EMIT_WT);

    always_comb
    begin
        hit   = (tbl_rdata.due <= now_reg);
        rearm = tbl_rdata.periodic && (tbl_rdata.repeats > REP_W'(1));
        keep  = !hit || rearm;
        upd   = tbl_rdata;
        if (hit && rearm)
        begin
            upd.repeats = tbl_rdata.repeats - REP_W'(1);
            upd.due     = now_reg + TIME_W'(tbl_rdata.period);
        end

        tbl_we    = 1'b0;
        tbl_waddr = wr_idx_reg[AW-1:0];
        tbl_wdata = upd;
        fire_we   = 1'b0;

        if (state_reg == S_SCAN && eval_vld_reg)
        begin
            case (op_reg)
                REQ_CANCEL:
                begin
                    // move survivors down unchanged
                    tbl_we    = (tbl_rdata.id != id_reg);
                    tbl_wdata = tbl_rdata;
                end
                REQ_TICK:
                begin
                    tbl_we  = keep;
                    fire_we = hit;
                end
                default: tbl_we = 1'b0;
            endcase
        end
        else if (state_reg == S_FINISH && out_free && id_reg != '0
                 && (op_reg == REQ_SCHEDULE || op_reg == REQ_PERIODIC)
                 && !found_reg && used_reg != FULL_CNT)
        begin
            // append at the tail
            tbl_we             = 1'b1;
            tbl_waddr          = used_reg[AW-1:0];
            tbl_wdata.id       = id_reg;
            tbl_wdata.periodic = (op_reg == REQ_PERIODIC);
            if (op_reg == REQ_PERIODIC)
            begin
                tbl_wdata.due     = now_reg;
                tbl_wdata.repeats = rep_reg;
                tbl_wdata.period  = period_reg;
            end
            else
            begin
                tbl_wdata.due     = now_reg + TIME_W'(delay_reg);
                tbl_wdata.repeats = '0;
                tbl_wdata.period  = '0;
            end
        end
    end

    tat_ram #(.W(ENTRY_W), .D(TABLE_DEPTH)) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (rd_idx_reg[AW-1:0]),
        .rdata (tbl_rdata)
    );

    tat_ram #(.W(ID_W), .D(TABLE_DEPTH)) u_fired (
        .clk   (clk),
        .we    (fire_we),
        .waddr (nf_reg[AW-1:0]),
        .wdata (tbl_rdata.id),
        .raddr (k_reg[AW-1:0]),
        .rdata (fire_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            now_reg      <= '0;
            used_reg     <= '0;
            rd_idx_reg   <= '0;
            wr_idx_reg   <= '0;
            nf_reg       <= '0;
            k_reg        <= '0;
            eval_vld_reg <= 1'b0;
            found_reg    <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            if (load_beat)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_vld_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        op_reg       <= in_ch.req_type;
                        id_reg       <= in_ch.action_id;
                        delay_reg    <= in_ch.delay;
                        period_reg   <= in_ch.period;
                        rep_reg      <= in_ch.repeat_total;
                        rd_idx_reg   <= '0;
                        wr_idx_reg   <= '0;
                        nf_reg       <= '0;
                        eval_vld_reg <= 1'b0;
                        found_reg    <= 1'b0;
                        if (in_ch.req_type == REQ_TICK)
                        begin
                            now_reg <= now_reg + TIME_W'(1);
                        end
                        if (in_ch.req_type == REQ_PERIODIC
                            || (in_ch.req_type == REQ_SCHEDULE && in_ch.action_id == '0))
                        begin
                            state_reg <= S_FINISH;
                        end
                        else
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                end

                S_SCAN:
                begin
                    // read slot i while slot i-1 is evaluated
                    eval_vld_reg <= issue;
                    if (issue)
                    begin
                        rd_idx_reg <= rd_idx_reg + CW'(1);
                    end
                    if (eval_vld_reg)
                    begin
                        if (tbl_we)
                        begin
                            wr_idx_reg <= wr_idx_reg + CW'(1);
                        end
                        if (fire_we)
                        begin
                            nf_reg <= nf_reg + CW'(1);
                        end
                        if (op_reg == REQ_SCHEDULE && tbl_rdata.id == id_reg)
                        begin
                            found_reg <= 1'b1;
                        end
                    end
                    if (!issue && !eval_vld_reg)
                    begin
                        state_reg <= S_FINISH;
                    end
                end

                S_FINISH:
                begin
                    if (out_free)
                    begin
                        out_last_reg <= 1'b1;
                        case (op_reg)
                            REQ_CANCEL:
                            begin
                                state_reg      <= S_IDLE;
                                out_id_reg     <= id_reg;
                                used_reg       <= wr_idx_reg;
                                out_used_reg   <= wr_idx_reg;
                                out_status_reg <= (wr_idx_reg != used_reg) ? ST_CANCELLED
                                                                           : ST_NOT_FOUND;
                            end
                            REQ_TICK:
                            begin
                                used_reg <= wr_idx_reg;
                                k_reg    <= '0;
                                if (nf_reg == '0)
                                begin
                                    state_reg      <= S_IDLE;
                                    out_used_reg   <= wr_idx_reg;
                                    out_status_reg <= ST_NONE_DUE;
                                    out_id_reg     <= '0;
                                end
                                else
                                begin
                                    state_reg <= S_EMIT_RD;
                                end
                            end
                            default:
                            begin
                                state_reg    <= S_IDLE;
                                out_id_reg   <= id_reg;
                                out_used_reg <= used_reg;
                                if (id_reg == '0)
                                begin
                                    out_status_reg <= ST_INVALID;
                                end
                                else if (found_reg)
                                begin
                                    out_status_reg <= ST_DUPLICATE;
                                end
                                else if (used_reg == FULL_CNT)
                                begin
                                    out_status_reg <= ST_FULL;
                                end
                                else
                                begin
                                    out_status_reg <= ST_SCHEDULED;
                                    used_reg       <= used_reg + CW'(1);
                                    out_used_reg   <= used_reg + CW'(1);
                                end
                            end
                        endcase
                    end
                end

                S_EMIT_RD:
                begin
                    state_reg <= S_EMIT_WT;
                end

                S_EMIT_WT:
                begin
                    if (out_free)
                    begin
                        out_status_reg <= ST_FIRED;
                        out_id_reg     <= fire_rdata;
                        out_used_reg   <= used_reg;
                        out_last_reg   <= (k_reg + CW'(1) == nf_reg);
                        k_reg          <= k_reg + CW'(1);
                        state_reg      <= (k_reg + CW'(1) == nf_reg) ? S_IDLE : S_EMIT_RD;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

`default_nettype wire

@@ rtl/tat_checker.sv @@
`default_nettype none

module tat_checker #(
    parameter int TABLE_DEPTH = tat_pkg::TAT_DEPTH_DEFAULT,
    parameter int CW          = $clog2(TABLE_DEPTH + 1)
) (
    input wire logic                     clk,
    input wire logic                     rst_n,
    input wire logic                     in_valid,
    input wire logic                     in_ready,
    input wire logic                     out_valid,
    input wire logic                     out_ready,
    input wire logic [2:0]               out_status,
    input wire logic [tat_pkg::ID_W-1:0] out_fired_id,
    input wire logic [CW-1:0]            out_used,
    input wire logic                     out_last
);
    import tat_pkg::*;

    // a stalled beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_status)
                                    && $stable(out_fired_id) && $stable(out_last))
        else $error("result beat changed while stalled");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while busy");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_status != ST_FIRED |-> out_last)
        else $error("non-fired result not last");

    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_used <= CW'(TABLE_DEPTH))
        else $error("occupancy beyond table depth");

    a_none_due_id: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_status == ST_NONE_DUE || out_status == ST_INVALID)
            |-> out_fired_id == '0)
        else $error("id on none-due or invalid result");
endmodule

bind timed_action_table tat_checker #(.TABLE_DEPTH(TABLE_DEPTH), .CW(CW)) u_tat_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_status   (out_ch.status),
    .out_fired_id (out_ch.fired_id),
    .out_used     (out_ch.entries_in_use),
    .out_last     (out_ch.last)
);

`default_nettype wire

@@ test/tb.sv @@
`default_nettype none

module tb;
    import tat_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 16;

    typedef struct packed {
        status_t          status;
        logic [ID_W-1:0]  fired_id;
        logic [4:0]       entries_in_use;
        logic             last;
    } beat_t;

    typedef struct {
        req_t              req;
        logic [ID_W-1:0]   id;
        logic [SPAN_W-1:0] delay;
        logic [SPAN_W-1:0] period;
        logic [REP_W-1:0]  reps;
        bit                typed;
        status_t           want_status;
        logic [ID_W-1:0]   want_id;
        logic [4:0]        want_used;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    tat_in_if        in_ch();
    tat_out_if #(5)  out_ch();

    timed_action_table #(.TABLE_DEPTH(DEPTH)) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always #5 clk = ~clk;

    // table mirror
    logic [TIME_W-1:0] now_q;
    int                used_q;
    entry_t            slots [DEPTH];

    beat_t want_q[$];
    int    n_pushed = 0;
    int    errors = 0;
    int    send_gap = 0;
    int    recv_gap = 0;

    task automatic report(input string what, input beat_t got, input beat_t exp);
        $display("mismatch %s: got st=%0d id=%0d use=%0d last=%0b exp st=%0d id=%0d use=%0d last=%0b",
                 what, got.status, got.fired_id, got.entries_in_use, got.last,
                 exp.status, exp.fired_id, exp.entries_in_use, exp.last);
        errors++;
    endtask

    function automatic void queue_beat(beat_t b);
        want_q = {want_q, b};
        n_pushed++;
    endfunction

    function automatic void push_one(status_t st, logic [ID_W-1:0] id);
        beat_t b;
        b.status = st;
        b.fired_id = id;
        b.entries_in_use = used_q[4:0];
        b.last = 1'b1;
        queue_beat(b);
    endfunction

    // advance the mirror by one request and queue the beats it produces
    function automatic void predict_table(req_t req, logic [ID_W-1:0] id,
                                          logic [SPAN_W-1:0] dly,
                                          logic [SPAN_W-1:0] per,
                                          logic [REP_W-1:0] reps);
        logic [ID_W-1:0] fired [$];
        int w;
        bit dup;
        bit keep;
        beat_t b;
        fired = {};
        w = 0;
        dup = 0;
        case (req)
            REQ_SCHEDULE, REQ_PERIODIC:
            begin
                if (id == '0)
                    push_one(ST_INVALID, '0);
                else
                begin
                    if (req == REQ_SCHEDULE)
                        for (int i = 0; i < used_q; i++)
                            if (slots[i].id == id)
                                dup = 1;
                    if (dup)
                        push_one(ST_DUPLICATE, id);
                    else if (used_q >= DEPTH)
                        push_one(ST_FULL, id);
                    else
                    begin
                        slots[used_q].id = id;
                        slots[used_q].periodic = (req == REQ_PERIODIC);
                        slots[used_q].due = (req == REQ_PERIODIC) ? now_q
                                                                  : now_q + TIME_W'(dly);
                        slots[used_q].repeats = (req == REQ_PERIODIC) ? reps : '0;
                        slots[used_q].period = (req == REQ_PERIODIC) ? per : '0;
                        used_q++;
                        push_one(ST_SCHEDULED, id);
                    end
                end
            end
            REQ_CANCEL:
            begin
                for (int i = 0; i < used_q; i++)
                    if (slots[i].id != id)
                    begin
                        slots[w] = slots[i];
                        w++;
                    end
                dup = (w < used_q);
                used_q = w;
                push_one(dup ? ST_CANCELLED : ST_NOT_FOUND, id);
            end
            default:
            begin
                now_q = now_q + 1'b1;
                for (int i = 0; i < used_q; i++)
                begin
                    keep = 1;
                    if (slots[i].due <= now_q)
                    begin
                        fired = {fired, slots[i].id};
                        if (slots[i].periodic && slots[i].repeats > 1)
                        begin
                            slots[i].repeats = slots[i].repeats - 1'b1;
                            slots[i].due = now_q + TIME_W'(slots[i].period);
                        end
                        else
                            keep = 0;
                    end
                    if (keep)
                    begin
                        slots[w] = slots[i];
                        w++;
                    end
                end
                used_q = w;
                if (fired.size() == 0)
                    push_one(ST_NONE_DUE, '0);
                else
                    foreach (fired[k])
                    begin
                        b.status = ST_FIRED;
                        b.fired_id = fired[k];
                        b.entries_in_use = used_q[4:0];
                        b.last = (k == fired.size() - 1);
                        queue_beat(b);
                    end
            end
        endcase
    endfunction

    // sender: drive at falling edge, hold until accepted
    task automatic send_req(input req_t req, input logic [ID_W-1:0] id,
                            input logic [SPAN_W-1:0] dly, input logic [SPAN_W-1:0] per,
                            input logic [REP_W-1:0] reps);
        while ($urandom_range(99) < send_gap)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.req_type <= req;
        in_ch.action_id <= id;
        in_ch.delay <= dly;
        in_ch.period <= per;
        in_ch.repeat_total <= reps;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predict_table(req, id, dly, per, reps);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (want_q.size() != 0)
            @(negedge clk);
    endtask

    // receiver
    always @(negedge clk)
        out_ch.ready <= ($urandom_range(99) >= recv_gap);

    always @(posedge clk)
    begin
        beat_t got;
        beat_t exp;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.status = out_ch.status;
            got.fired_id = out_ch.fired_id;
            got.entries_in_use = out_ch.entries_in_use;
            got.last = out_ch.last;
            if (want_q.size() == 0)
            begin
                exp = '0;
                report("unexpected beat", got, exp);
            end
            else
            begin
                exp = want_q.pop_front();
                if (got !== exp)
                    report("beat", got, exp);
            end
        end
    end

    function automatic row_t mk(req_t r, logic [ID_W-1:0] id, logic [SPAN_W-1:0] d,
                                logic [SPAN_W-1:0] p, logic [REP_W-1:0] n);
        row_t x;
        x.req = r; x.id = id; x.delay = d; x.period = p; x.reps = n;
        x.typed = 0; x.want_status = ST_SCHEDULED; x.want_id = '0; x.want_used = '0;
        return x;
    endfunction

    function automatic row_t mkx(req_t r, logic [ID_W-1:0] id, logic [SPAN_W-1:0] d,
                                 status_t st, logic [ID_W-1:0] wid, logic [4:0] u);
        row_t x;
        x = mk(r, id, d, '0, '0);
        x.typed = 1; x.want_status = st; x.want_id = wid; x.want_used = u;
        return x;
    endfunction

    task automatic random_req(input int live);
        int pick;
        logic [ID_W-1:0] id;
        pick = $urandom_range(99);
        id = (live > 0 && $urandom_range(1)) ? 16'($urandom_range(1, 12)) : 16'($urandom);
        if ($urandom_range(30) == 0)
            id = '0;
        if (pick < 30)
            send_req(REQ_SCHEDULE, id,
                     ($urandom_range(9) == 0) ? 24'($urandom) : 24'($urandom_range(0, 6)),
                     24'($urandom), 16'($urandom));
        else if (pick < 45)
            send_req(REQ_PERIODIC, id, 24'($urandom),
                     ($urandom_range(9) == 0) ? 24'($urandom) : 24'($urandom_range(0, 4)),
                     ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4)));
        else if (pick < 55)
            send_req(REQ_CANCEL, id, 24'($urandom), 24'($urandom), 16'($urandom));
        else
            send_req(REQ_TICK, 16'($urandom), 24'($urandom), 24'($urandom), 16'($urandom));
    endtask

    initial
    begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        row_t rows [$];
        int   start;
        beat_t exp;
        beat_t got_row;
        in_ch.valid = 1'b0;
        in_ch.req_type = REQ_TICK;
        in_ch.action_id = '0;
        in_ch.delay = '0;
        in_ch.period = '0;
        in_ch.repeat_total = '0;
        out_ch.ready = 1'b0;
        now_q = '0;
        used_q = 0;

        rows = {rows, mkx(REQ_TICK, 16'h0, 24'h0, ST_NONE_DUE, 16'h0, 5'd0)};
        rows = {rows, mkx(REQ_SCHEDULE, 16'h0, 24'h5, ST_INVALID, 16'h0, 5'd0)};
        rows = {rows, mkx(REQ_PERIODIC, 16'h0, 24'h0, ST_INVALID, 16'h0, 5'd0)};
        rows = {rows, mkx(REQ_CANCEL, 16'h0, 24'h0, ST_NOT_FOUND, 16'h0, 5'd0)};
        rows = {rows, mkx(REQ_SCHEDULE, 16'hFFFF, 24'hFFFFFF, ST_SCHEDULED, 16'hFFFF, 5'd1)};
        rows = {rows, mkx(REQ_SCHEDULE, 16'hFFFF, 24'h0, ST_DUPLICATE, 16'hFFFF, 5'd1)};
        rows = {rows, mkx(REQ_SCHEDULE, 16'h0001, 24'h0, ST_SCHEDULED, 16'h0001, 5'd2)};
        rows = {rows, mk(REQ_PERIODIC, 16'h0001, 24'h0, 24'h0, 16'd3)};
        rows = {rows, mk(REQ_PERIODIC, 16'h0002, 24'hFFFFFF, 24'h2, 16'hFFFF)};
        rows = {rows, mk(REQ_PERIODIC, 16'h0003, 24'h0, 24'hFFFFFF, 16'd0)};
        rows = {rows, mk(REQ_TICK, 16'h0, 24'h0, 24'h0, 16'h0)};
        rows = {rows, mk(REQ_TICK, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF)};
        rows = {rows, mkx(REQ_CANCEL, 16'h0002, 24'h0, ST_CANCELLED, 16'h0002, 5'd2)};
        for (int i = 0; i < 14; i++)
            rows = {rows, mk(REQ_PERIODIC, 16'h0010, 24'h0, 24'h9, 16'd2)};
        rows = {rows, mk(REQ_SCHEDULE, 16'h0020, 24'h1, 24'h0, 16'h0)};
        rows = {rows, mk(REQ_TICK, 16'h0, 24'h0, 24'h0, 16'h0)};
        rows = {rows, mk(REQ_CANCEL, 16'h0010, 24'h0, 24'h0, 16'h0)};

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_gap = 14;
        recv_gap = 88;
        foreach (rows[r])
        begin
            start = n_pushed;
            send_req(rows[r].req, rows[r].id, rows[r].delay, rows[r].period, rows[r].reps);
            if (rows[r].typed)
            begin
                exp.status = rows[r].want_status;
                exp.fired_id = rows[r].want_id;
                exp.entries_in_use = rows[r].want_used;
                exp.last = 1'b1;
                got_row = '0;
                if (want_q.size() != 0)
                    got_row = want_q[$];
                if (n_pushed != start + 1 || got_row !== exp)
                    report("table row", got_row, exp);
            end
        end

        // hold the sender until the table has answered everything
        wait_drained();

        for (int n = 0; n < 250; n++)
        begin
            if (n == 83)
            begin
                send_gap = 88;
                recv_gap = 14;
            end
            else if (n == 166)
            begin
                send_gap = 0;
                recv_gap = 0;
            end
            random_req(used_q);
        end

        wait_drained();
        repeat (100) @(posedge clk);
        if (errors == 0 && want_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
